>>> rtl/core/bst_pkg.sv
`default_nettype none

package bst_pkg;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/bst_in_if.sv
`default_nettype none

interface bst_in_if;
  import bst_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [DATA_W-1:0]   item_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, op, item_value, position, input ready);
  modport sink   (input valid, op, item_value, position, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bst_out_if.sv
`default_nettype none

interface bst_out_if;
  import bst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  found;
  logic [POS_W-1:0]      found_index;
  logic [DATA_W-1:0]     read_value;
  logic [COUNT_W-1:0]    entry_count;

  modport source (output valid, status, found, found_index, read_value, entry_count,
                  input ready);
  modport sink   (input valid, status, found, found_index, read_value, entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/bst_ram.sv
`default_nettype none

module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bounded_set_table.sv
// An in-range read goes from idle through a RAM read wait to done; an add or
// query scans the entries up to the first match, then decides and finishes, and
// a remove that hits also shifts the later entries down. Throughput: one item at
// a time; the next input beat is taken once the result is registered and the
// block is idle again, so the entry count and any output stall set the item time.
// Reset clears count and output valid and loads the limit with 10, not the entries.
`default_nettype none

module bounded_set_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bst_in_if.sink                      in_if,
  bst_out_if.source                   out_if,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [bst_pkg::LIMIT_W-1:0] cfg_entry_limit
);
  import bst_pkg::*;

  localparam int EW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [EW-1:0]       val_r, val_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       hidx_r, hidx_nxt;
  logic                pend_r, pend_nxt;
  logic                hit_r, hit_nxt;
  status_t             status_r, status_nxt;
  logic [DATA_W-1:0]   rdv_r, rdv_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_found_r, out_found_nxt;
  logic [POS_W-1:0]    out_index_r, out_index_nxt;
  logic [DATA_W-1:0]   out_rdv_r, out_rdv_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;
  logic                is_full;

  bst_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_full = (32'(count_r) >= 32'(limit_r)) || (32'(count_r) >= MAX_ENTRIES);

  assign in_if.ready = (state_r == S_IDLE);
  assign cfg_ready   = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.found       = out_found_r;
  assign out_if.found_index = out_index_r;
  assign out_if.read_value  = out_rdv_r;
  assign out_if.entry_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    hidx_nxt       = hidx_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    rdv_nxt        = rdv_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_index_nxt  = out_index_r;
    out_rdv_nxt    = out_rdv_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = IW'(count_r);
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = IW'(idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt     = op_t'(in_if.op);
          val_nxt    = in_if.item_value[EW-1:0];
          idx_nxt    = '0;
          hidx_nxt   = '0;
          pend_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          rdv_nxt    = '0;
          if (op_t'(in_if.op) == OP_READ) begin
            if (32'(in_if.position) < 32'(count_r)) begin
              ram_re    = 1'b1;
              ram_raddr = IW'(in_if.position);
              state_nxt = S_RDWAIT;
            end else begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (pend_r && (ram_rdata == val_r)) begin
          hit_nxt   = 1'b1;
          hidx_nxt  = idx_r - CW'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end else if (idx_r < count_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_ADD: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else if (hit_r) begin
              status_nxt = ST_DUP;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_REMOVE: begin
            if (!hit_r) begin
              status_nxt = ST_MISSING;
            end else begin
              idx_nxt   = hidx_r + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(idx_r - CW'(2));
          ram_wdata = ram_rdata;
        end
        if (idx_r < count_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_RDWAIT: begin
        rdv_nxt   = DATA_W'(ram_rdata);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = hit_r;
          out_index_nxt  = hit_r ? POS_W'(hidx_r) : '0;
          out_rdv_nxt    = rdv_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_entry_limit;
      end
    end
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    hidx_r       <= hidx_nxt;
    hit_r        <= hit_nxt;
    status_r     <= status_nxt;
    rdv_r        <= rdv_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_index_r  <= out_index_nxt;
    out_rdv_r    <= out_rdv_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/bst_checker.sv
`default_nettype none

module bst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic        out_found,
  input wire logic [3:0]  out_found_index,
  input wire logic [31:0] out_read_value,
  input wire logic [4:0]  out_entry_count
);
  import bst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_read_value)
                               && $stable(out_entry_count))
    else $error("stalled result beat changed");

  a_index_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == '0)
    else $error("found index set for an absent value");

  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DUP) |-> out_found)
    else $error("duplicate reported without a match");

  a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANGE) |-> !out_found && (out_read_value == '0))
    else $error("out-of-range read carries data");

endmodule

bind bounded_set_table bst_checker u_bst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_found       (out_if.found),
  .out_found_index (out_if.found_index),
  .out_read_value  (out_if.read_value),
  .out_entry_count (out_if.entry_count)
);

`default_nettype wire

>>> test/bounded_set_table_tb.sv
`timescale 1ns / 1ps

module bounded_set_table_tb;
  import bst_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 4;
  localparam int TABLE_DEPTH = 16;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 178;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [POS_W-1:0]    found_index;
    logic [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]  entry_count;
  } set_result_t;

  typedef struct {
    op_t                op;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   position;
    bit                 typed;
    set_result_t        lit;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_entry_limit;

  bst_in_if in_ch();
  bst_out_if out_ch();

  bounded_set_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_if           (in_ch),
    .out_if          (out_ch),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_entry_limit (cfg_entry_limit)
  );

  always #(CLK_HALF) clk = ~clk;

  logic [DATA_W-1:0] set_entries [TABLE_DEPTH];
  int set_count = 0;
  int set_limit = LIMIT_RESET;
  set_result_t expected_results[$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int sink_idle_pct = 0;
  bit long_hold_req = 1'b0;
  logic [DATA_W-1:0] value_base = '0;

  logic [LIMIT_W-1:0] limit_plan [PHASE_COUNT] = '{
    5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'd16, 5'd2, 5'd20, 5'd10, 5'd1
  };

  directed_row_t directed_rows [24] = '{
    '{OP_READ,   32'h0000_0000, 4'd0,  1'b1, '{ST_RANGE,   1'b0, 4'd0, 32'h0, 5'd0}},
    '{OP_QUERY,  32'h0000_0000, 4'd0,  1'b1, '{ST_OK,      1'b0, 4'd0, 32'h0, 5'd0}},
    '{OP_REMOVE, 32'h0000_0005, 4'd0,  1'b1, '{ST_MISSING, 1'b0, 4'd0, 32'h0, 5'd0}},
    '{OP_ADD,    32'h0000_0000, 4'd0,  1'b1, '{ST_OK,      1'b0, 4'd0, 32'h0, 5'd1}},
    '{OP_ADD,    32'hFFFF_FFFF, 4'd15, 1'b1, '{ST_OK,      1'b0, 4'd0, 32'h0, 5'd2}},
    '{OP_ADD,    32'h0000_0000, 4'd0,  1'b1, '{ST_DUP,     1'b1, 4'd0, 32'h0, 5'd2}},
    '{OP_READ,   32'h0000_0000, 4'd1,  1'b1,
      '{ST_OK, 1'b0, 4'd0, 32'hFFFF_FFFF, 5'd2}},
    '{OP_READ,   32'hFFFF_FFFF, 4'd15, 1'b1, '{ST_RANGE,   1'b0, 4'd0, 32'h0, 5'd2}},
    '{OP_QUERY,  32'hFFFF_FFFF, 4'd0,  1'b1, '{ST_OK,      1'b1, 4'd1, 32'h0, 5'd2}},
    '{OP_ADD,    32'h5555_5555, 4'd5,  1'b0, '0},
    '{OP_ADD,    32'hAAAA_AAAA, 4'd10, 1'b0, '0},
    '{OP_ADD,    32'h0000_0001, 4'd0,  1'b0, '0},
    '{OP_ADD,    32'h8000_0000, 4'd0,  1'b0, '0},
    '{OP_ADD,    32'h7FFF_FFFF, 4'd0,  1'b0, '0},
    '{OP_ADD,    32'h1234_5678, 4'd0,  1'b0, '0},
    '{OP_ADD,    32'hC3C3_3C3C, 4'd0,  1'b0, '0},
    '{OP_ADD,    32'h0F0F_F0F0, 4'd0,  1'b0, '0},
    '{OP_ADD,    32'h0000_0007, 4'd0,  1'b1, '{ST_FULL,    1'b0, 4'd0, 32'h0, 5'd10}},
    '{OP_ADD,    32'h0000_0000, 4'd0,  1'b1, '{ST_FULL,    1'b1, 4'd0, 32'h0, 5'd10}},
    '{OP_REMOVE, 32'h0000_0000, 4'd0,  1'b0, '0},
    '{OP_REMOVE, 32'h8000_0000, 4'd0,  1'b0, '0},
    '{OP_REMOVE, 32'h0F0F_F0F0, 4'd0,  1'b0, '0},
    '{OP_READ,   32'h0000_0000, 4'd6,  1'b0, '0},
    '{OP_QUERY,  32'h8000_0000, 4'd0,  1'b0, '0}
  };

  // Lookup returns the first match among the valid entries; a remove closes
  // the gap by shifting every later entry down by one place.
  function automatic set_result_t apply_request(input op_t op, input logic [DATA_W-1:0] value,
                                                input logic [POS_W-1:0] pos);
    set_result_t res;
    int hit;
    int cap;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    cap = (set_limit < TABLE_DEPTH) ? set_limit : TABLE_DEPTH;
    if (op != OP_READ) begin
      for (int i = 0; i < set_count; i++) begin
        if (hit < 0 && set_entries[i] == value) hit = i;
      end
    end
    case (op)
      OP_ADD: begin
        if (set_count >= cap) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_DUP;
        end else begin
          set_entries[set_count] = value;
          set_count++;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          for (int i = hit; i + 1 < set_count; i++) set_entries[i] = set_entries[i + 1];
          set_count--;
        end
      end
      OP_QUERY: begin
      end
      default: begin
        if (int'(pos) < set_count) res.read_value = set_entries[pos];
        else res.status = ST_RANGE;
      end
    endcase
    res.found = (hit >= 0);
    res.found_index = (hit >= 0) ? POS_W'(hit) : '0;
    res.entry_count = COUNT_W'(set_count);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
      mismatch_count++;
    end
  endtask

  task automatic offer_request(input op_t op, input logic [DATA_W-1:0] value,
                               input logic [POS_W-1:0] pos, input bit typed,
                               input set_result_t lit);
    set_result_t predicted;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.item_value <= value;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(op, value, pos);
    expected_results.push_back(typed ? lit : predicted);
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_random_request();
    int r;
    op_t op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_ADD;
    else if (r < 60) op = OP_REMOVE;
    else if (r < 80) op = OP_QUERY;
    else op = OP_READ;
    r = $urandom_range(0, 99);
    if (r < 45 && set_count > 0) value = set_entries[$urandom_range(0, set_count - 1)];
    else if (r < 85) value = value_base ^ DATA_W'($urandom_range(0, 23));
    else value = $urandom();
    if ($urandom_range(0, 1) == 0 && set_count > 0) pos = POS_W'($urandom_range(0, set_count - 1));
    else pos = POS_W'($urandom_range(0, 15));
    offer_request(op, value, pos, 1'b0, '0);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_entry_limit(input logic [LIMIT_W-1:0] lim);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_entry_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    set_limit = lim;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_ADD;
    in_ch.item_value <= '0;
    in_ch.position <= '0;
    cfg_valid <= 1'b0;
    cfg_entry_limit <= LIMIT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 20;
    sink_idle_pct = 20;
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].position,
                    directed_rows[i].typed, directed_rows[i].lit);
    end
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_entry_limit(limit_plan[p]);
      value_base = $urandom() & 32'hFFFF_FFE0;
      sender_idle_pct = (p % 3 == 2) ? 0 : 30;
      sink_idle_pct = (p % 4 == 2) ? 0 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) long_hold_req = 1'b1;
        if (p == 5 && n == 90) wait_for_results();
        offer_random_request();
      end
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bounded_set_table test passed");
    end else begin
      $display("bounded_set_table test failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < sink_idle_pct) stall_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding: status %0d, count %0d",
               out_ch.status, out_ch.entry_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(out_ch.status));
        check_field("found", DATA_W'(want.found), DATA_W'(out_ch.found));
        check_field("found_index", DATA_W'(want.found_index), DATA_W'(out_ch.found_index));
        check_field("read_value", want.read_value, out_ch.read_value);
        check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(out_ch.entry_count));
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("bounded_set_table test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bst_pkg.sv
rtl/core/bst_in_if.sv
rtl/core/bst_out_if.sv
rtl/core/bst_ram.sv
rtl/core/bounded_set_table.sv
rtl/core/bst_checker.sv
test/bounded_set_table_tb.sv
